// File: src/ttsb_pkg.sv
package ttsb_pkg;

    // Field widths on the stream ports
    localparam int KIND_W = 2;
    localparam int BYTE_W = 8;
    localparam int ROW_W  = 4;
    localparam int COL_W  = 5;
    localparam int CHAR_W = 7;

    // s_tdata: byte_in, read_row, read_col, padded to whole bytes
    localparam int S_TDATA_W = 24;
    // m_tdata: cell_char, cursor_row, cursor_col
    localparam int M_TDATA_W = 16;

    localparam int NUM_ROWS_DEFAULT = 15;
    localparam int NUM_COLS_DEFAULT = 20;

    localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    localparam logic [BYTE_W-1:0] CR_BYTE         = 8'd13;
    localparam logic [BYTE_W-1:0] LF_BYTE         = 8'd10;
    localparam logic [BYTE_W-1:0] FIRST_PRINTABLE = 8'd32;
    localparam logic [BYTE_W-1:0] LAST_PRINTABLE  = 8'd126;
    localparam logic [CHAR_W-1:0] SPACE_CHAR      = 7'd32;

    typedef struct packed {
        logic start;      // input transaction accepted this cycle
        logic load_read;  // move registered cell read into the result register
    } cmd_t;

endpackage

// File: src/text_terminal_scroll_buffer_unit.sv
// Character terminal buffer of NUM_ROWS by NUM_COLS cells with line scroll.
//
// Input channel (s_): one transaction per item. s_tuser carries the kind:
// put byte, read cell or clear buffer. s_tdata carries the byte to place and
// the displayed row and column to read. Output channel (m_): one transaction
// per input item with the character read (space for put and clear) and the
// cursor position after the item.
//
// Put and clear results are registered at the accepting edge, and a new
// item is taken every cycle while the output drains and no read is pending.
// A read item passes the registered read of the cell memory, then the read
// state loads the result register; no input is taken in the read state.
//
// Reset (aresetn low, synchronous) empties all rows, homes the cursor and the
// top-row pointer and drops any pending result; no clearing pass is needed.
// When m_tready is low the result register holds and s_tready drops until the
// result is taken.
module text_terminal_scroll_buffer_unit #(
    parameter int NUM_ROWS = ttsb_pkg::NUM_ROWS_DEFAULT,
    parameter int NUM_COLS = ttsb_pkg::NUM_COLS_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ttsb_pkg::S_TDATA_W-1:0] s_tdata,  // byte_in, read_row, read_col
    input  logic [ttsb_pkg::KIND_W-1:0]    s_tuser,  // kind
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ttsb_pkg::M_TDATA_W-1:0] m_tdata   // cell_char, cursor_row, cursor_col
);
    import ttsb_pkg::*;

    localparam int ROW_LO = BYTE_W;
    localparam int COL_LO = BYTE_W + ROW_W;
    localparam int M_USED = CHAR_W + ROW_W + COL_W;

    cmd_t              cmd;
    logic              is_read;
    logic [CHAR_W-1:0] cell_char;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;

    ttsb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .is_read  (is_read),
        .cmd      (cmd)
    );

    ttsb_dp #(
        .NUM_ROWS (NUM_ROWS),
        .NUM_COLS (NUM_COLS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .kind       (s_tuser),
        .byte_in    (s_tdata[BYTE_W-1:0]),
        .read_row   (s_tdata[ROW_LO +: ROW_W]),
        .read_col   (s_tdata[COL_LO +: COL_W]),
        .is_read    (is_read),
        .cell_char  (cell_char),
        .cursor_row (cursor_row),
        .cursor_col (cursor_col)
    );

    assign m_tdata = {{(M_TDATA_W - M_USED){1'b0}}, cursor_col, cursor_row, cell_char};

endmodule

// File: src/ttsb_ctrl.sv
module ttsb_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    input  logic            is_read,
    output ttsb_pkg::cmd_t  cmd
);
    import ttsb_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    assign s_tready      = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign accept        = s_tvalid && s_tready;
    assign m_tvalid      = out_valid_reg;
    assign cmd.start     = accept;
    assign cmd.load_read = (state_reg == ST_READ);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && is_read) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        if ((accept && !is_read) || cmd.load_read) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The read state always finds the result register empty
    a_read_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_READ |-> !out_valid_reg)
        else $error("cell read completes while result register is full");

    a_read_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && is_read |=> state_reg == ST_READ && !out_valid_reg)
        else $error("read transaction did not start a cell fetch");

    a_read_result: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_READ |=> out_valid_reg && state_reg == ST_IDLE)
        else $error("cell fetch did not produce a result");

    a_direct_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !is_read |=> out_valid_reg)
        else $error("non-read transaction did not produce a result");

endmodule

// File: src/ttsb_dp.sv
module ttsb_dp #(
    parameter int NUM_ROWS = ttsb_pkg::NUM_ROWS_DEFAULT,
    parameter int NUM_COLS = ttsb_pkg::NUM_COLS_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  ttsb_pkg::cmd_t              cmd,
    input  logic [ttsb_pkg::KIND_W-1:0] kind,
    input  logic [ttsb_pkg::BYTE_W-1:0] byte_in,
    input  logic [ttsb_pkg::ROW_W-1:0]  read_row,
    input  logic [ttsb_pkg::COL_W-1:0]  read_col,
    output logic                        is_read,
    output logic [ttsb_pkg::CHAR_W-1:0] cell_char,
    output logic [ttsb_pkg::ROW_W-1:0]  cursor_row,
    output logic [ttsb_pkg::COL_W-1:0]  cursor_col
);
    import ttsb_pkg::*;

    localparam int RW    = $clog2(NUM_ROWS);
    localparam int CW    = $clog2(NUM_COLS + 1);
    localparam int DEPTH = NUM_ROWS * NUM_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [RW-1:0] LAST_ROW = RW'(NUM_ROWS - 1);
    localparam logic [RW:0]   ROWS_X   = (RW + 1)'(NUM_ROWS);
    localparam logic [CW-1:0] FULL_COL = CW'(NUM_COLS);
    localparam logic [AW-1:0] COLS_A   = AW'(NUM_COLS);

    logic [RW-1:0]     top_reg, top_next;
    logic [RW-1:0]     crow_reg, crow_next;
    logic [CW-1:0]     ccol_reg, ccol_next;
    logic [CW-1:0]     len_reg [NUM_ROWS];
    logic [CHAR_W-1:0] cell_mem [DEPTH];
    logic [CHAR_W-1:0] rd_data_reg;
    logic              rd_blank_reg;
    logic [CHAR_W-1:0] char_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [COL_W-1:0]  col_reg;

    logic              is_put, is_clear, is_cr, is_lf, printable;
    logic              put_write, wrap, do_lf, scroll;
    logic [CHAR_W-1:0] put_char;
    logic [RW-1:0]     top_adv, top_lf, crow_lf, wr_phys;
    logic [RW:0]       wr_sum;
    logic [CW-1:0]     col_base, col_inc;
    logic [AW-1:0]     wr_addr, rd_addr;
    logic              len_we, mem_we, rd_en;
    logic [RW-1:0]     len_idx;
    logic [CW-1:0]     len_val;
    logic              rd_in_range, rd_blank;
    logic [RW-1:0]     rrow, rd_phys;
    logic [CW-1:0]     rcol;
    logic [RW:0]       rd_sum;

    assign is_read  = (kind == KIND_READ);
    assign is_put   = (kind == KIND_PUT);
    assign is_clear = (kind == KIND_CLEAR);

    // Put path
    always_comb begin
        is_cr     = (byte_in == CR_BYTE);
        is_lf     = (byte_in == LF_BYTE);
        printable = (byte_in >= FIRST_PRINTABLE) && (byte_in <= LAST_PRINTABLE);
        put_char  = printable ? byte_in[CHAR_W-1:0] : SPACE_CHAR;
        put_write = is_put && !is_cr && !is_lf;
        wrap      = put_write && (ccol_reg == FULL_COL);
        do_lf     = (is_put && is_lf) || wrap;
        scroll    = do_lf && (crow_reg == LAST_ROW);
        top_adv   = (top_reg == LAST_ROW) ? '0 : top_reg + RW'(1);
        crow_lf   = do_lf && !scroll ? crow_reg + RW'(1) : crow_reg;
        top_lf    = scroll ? top_adv : top_reg;
        col_base  = do_lf ? '0 : ccol_reg;
        col_inc   = col_base + CW'(1);
        wr_sum    = {1'b0, top_lf} + {1'b0, crow_lf};
        wr_phys   = (wr_sum >= ROWS_X) ? RW'(wr_sum - ROWS_X) : wr_sum[RW-1:0];
        wr_addr   = AW'(wr_phys) * COLS_A + AW'(col_base);
        mem_we    = cmd.start && put_write;
        // On a wrapping scroll the written row is the old top row, so one write suffices
        len_we    = cmd.start && (put_write || scroll);
        len_idx   = put_write ? wr_phys : top_reg;
        len_val   = put_write ? col_inc : '0;
    end

    always_comb begin
        top_next  = top_reg;
        crow_next = crow_reg;
        ccol_next = ccol_reg;
        if (cmd.start) begin
            if (is_clear) begin
                top_next  = '0;
                crow_next = '0;
                ccol_next = '0;
            end else if (is_put) begin
                top_next  = top_lf;
                crow_next = crow_lf;
                if (put_write) begin
                    ccol_next = col_inc;
                end else if (do_lf) begin
                    ccol_next = '0;
                end
            end
        end
    end

    // Read path
    always_comb begin
        rd_in_range = (32'(read_row) < NUM_ROWS) && (32'(read_col) < NUM_COLS);
        rrow        = rd_in_range ? RW'(read_row) : '0;
        rcol        = rd_in_range ? CW'(read_col) : '0;
        rd_sum      = {1'b0, top_reg} + {1'b0, rrow};
        rd_phys     = (rd_sum >= ROWS_X) ? RW'(rd_sum - ROWS_X) : rd_sum[RW-1:0];
        rd_addr     = AW'(rd_phys) * COLS_A + AW'(rcol);
        rd_blank    = !rd_in_range || (rcol >= len_reg[rd_phys]);
        rd_en       = cmd.start && is_read;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_reg  <= '0;
            crow_reg <= '0;
            ccol_reg <= '0;
            for (int i = 0; i < NUM_ROWS; i++) begin
                len_reg[i] <= '0;
            end
        end else begin
            top_reg  <= top_next;
            crow_reg <= crow_next;
            ccol_reg <= ccol_next;
            if (cmd.start && is_clear) begin
                for (int i = 0; i < NUM_ROWS; i++) begin
                    len_reg[i] <= '0;
                end
            end else if (len_we) begin
                len_reg[len_idx] <= len_val;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            cell_mem[wr_addr] <= put_char;
        end
        if (rd_en) begin
            rd_data_reg  <= cell_mem[rd_addr];
            rd_blank_reg <= rd_blank;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.start && !is_read) begin
            char_reg <= SPACE_CHAR;
            row_reg  <= ROW_W'(crow_next);
            col_reg  <= COL_W'(ccol_next);
        end else if (cmd.load_read) begin
            char_reg <= rd_blank_reg ? SPACE_CHAR : rd_data_reg;
            row_reg  <= ROW_W'(crow_reg);
            col_reg  <= COL_W'(ccol_reg);
        end
    end

    assign cell_char  = char_reg;
    assign cursor_row = row_reg;
    assign cursor_col = col_reg;

endmodule

// File: tb/sv/tb.sv
module tb;
    import ttsb_pkg::*;

    localparam int NR = NUM_ROWS_DEFAULT;
    localparam int NC = NUM_COLS_DEFAULT;
    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 20;
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] byte_in;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        bit                drain_first;
    } term_item_t;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
    } screen_reply_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [KIND_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    text_terminal_scroll_buffer_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Shadow screen state
    logic [CHAR_W-1:0] shadow_cells [NR][NC];
    int shadow_len [NR];
    int top_row;
    int cur_row;
    int cur_col;

    term_item_t    pending_items[$];
    screen_reply_t expected_replies[$];
    term_item_t    cur_item;
    int err_cnt = 0;
    int cyc = 0;
    int src_gap = 0;
    int src_calm = 0;
    int dst_stall = 0;
    int dst_calm = 0;

    function automatic void shadow_line_feed();
        cur_col = 0;
        if (cur_row < NR - 1) begin
            cur_row++;
        end else begin
            // the old top row becomes the empty bottom row
            shadow_len[top_row] = 0;
            top_row = (top_row + 1) % NR;
        end
    endfunction

    function automatic void shadow_clear();
        for (int i = 0; i < NR; i++) shadow_len[i] = 0;
        top_row = 0;
        cur_row = 0;
        cur_col = 0;
    endfunction

    function automatic screen_reply_t apply_item(term_item_t it);
        screen_reply_t res;
        int prow;
        logic [BYTE_W-1:0] b;
        res.ch = SPACE_CHAR;
        b = it.byte_in;
        case (it.kind)
            KIND_PUT: begin
                if (b == LF_BYTE) begin
                    shadow_line_feed();
                end else if (b != CR_BYTE) begin
                    if (b < FIRST_PRINTABLE || b > LAST_PRINTABLE) b = BYTE_W'(SPACE_CHAR);
                    if (cur_col >= NC) shadow_line_feed();
                    prow = (top_row + cur_row) % NR;
                    shadow_cells[prow][cur_col] = b[CHAR_W-1:0];
                    cur_col++;
                    shadow_len[prow] = cur_col;
                end
            end
            KIND_READ: begin
                if (it.row < NR && it.col < NC) begin
                    prow = (top_row + it.row) % NR;
                    if (it.col < shadow_len[prow]) res.ch = shadow_cells[prow][it.col];
                end
            end
            KIND_CLEAR: begin
                shadow_clear();
            end
            default: begin
            end
        endcase
        res.row = ROW_W'(cur_row);
        res.col = COL_W'(cur_col);
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    function automatic void check_field(string what, int want, int got);
        if (want != got) begin
            err_cnt++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
        end
    endfunction

    function automatic void add_item(logic [KIND_W-1:0] kind, int b, int row, int col,
                                     bit drain = 1'b0);
        term_item_t it;
        it.kind = kind;
        it.byte_in = BYTE_W'(b);
        it.row = ROW_W'(row);
        it.col = COL_W'(col);
        it.drain_first = drain;
        pending_items.push_back(it);
    endfunction

    // Driver: present items from the pending queue, predict on each accepted transaction
    always @(posedge aclk) begin : driver
        logic nv;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            nv = s_tvalid;
            if (s_tvalid && s_tready) begin
                expected_replies.push_back(apply_item(cur_item));
                nv = 1'b0;
                src_gap = (src_calm > 0) ? 0 : pick_gap();
            end
            if (src_calm > 0) src_calm--;
            else if ($urandom_range(0, 49) == 0) src_calm = $urandom_range(20, 60);
            if (!nv) begin
                if (src_gap > 0) begin
                    src_gap--;
                end else if (pending_items.size() > 0 &&
                             (!pending_items[0].drain_first || expected_replies.size() == 0)) begin
                    cur_item = pending_items.pop_front();
                    s_tdata <= {7'd0, cur_item.col, cur_item.row, cur_item.byte_in};
                    s_tuser <= cur_item.kind;
                    nv = 1'b1;
                end
            end
            s_tvalid <= nv;
        end
    end

    // Monitor: compare each result transaction with the oldest prediction
    always @(posedge aclk) begin : monitor
        screen_reply_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_replies.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected result: expected none, actual %h", $time, m_tdata);
                end else begin
                    want = expected_replies.pop_front();
                    check_field("cell_char", want.ch, m_tdata[6:0]);
                    check_field("cursor_row", want.row, m_tdata[10:7]);
                    check_field("cursor_col", want.col, m_tdata[15:11]);
                end
            end
            if (dst_calm > 0) dst_calm--;
            else if ($urandom_range(0, 49) == 0) dst_calm = $urandom_range(20, 60);
            if (dst_stall > 0) begin
                dst_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (dst_calm == 0 && $urandom_range(0, 4) == 0) dst_stall = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        cyc++;
        if (cyc > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        term_item_t it;
        int r;
        int lf_pct;
        int clr_pct;

        for (int i = 0; i < NR; i++) begin
            for (int j = 0; j < NC; j++) shadow_cells[i][j] = '0;
        end
        shadow_clear();

        // directed: byte classes, reads at and past line end, out of range, kinds
        add_item(KIND_READ, 0, 0, 0);
        add_item(KIND_PUT, 72, 0, 0);
        add_item(KIND_PUT, 32, 0, 0);
        add_item(KIND_PUT, 126, 0, 0);
        add_item(KIND_PUT, 31, 0, 0);
        add_item(KIND_PUT, 127, 0, 0);
        add_item(KIND_PUT, 255, 0, 0);
        add_item(KIND_PUT, 0, 0, 0);
        add_item(KIND_PUT, CR_BYTE, 0, 0);
        add_item(KIND_READ, 0, 0, 0);
        add_item(KIND_READ, 0, 0, 3);
        add_item(KIND_READ, 0, 0, 6);
        add_item(KIND_READ, 0, 0, 7);
        add_item(KIND_READ, 0, 15, 0);
        add_item(KIND_READ, 0, 0, 31);
        add_item(KIND_READ, 0, 0, 20);
        add_item(KIND_NONE, 255, 15, 31);
        add_item(KIND_PUT, LF_BYTE, 0, 0);
        add_item(KIND_PUT, 120, 15, 31);
        add_item(KIND_READ, 255, 1, 0);
        add_item(KIND_CLEAR, 255, 15, 31);
        add_item(KIND_READ, 0, 0, 0);

        // random: text with line feeds, reads, noise; later chunks add long lines and clears
        for (int chunk = 0; chunk < 3; chunk++) begin
            lf_pct = (chunk == 0) ? 15 : (chunk == 1) ? 2 : 10;
            clr_pct = (chunk == 2) ? 2 : 0;
            for (int n = 0; n < 150; n++) begin
                it.kind = KIND_PUT;
                it.byte_in = BYTE_W'($urandom_range(0, 255));
                it.row = ROW_W'($urandom_range(0, 15));
                it.col = COL_W'($urandom_range(0, 31));
                it.drain_first = (n == 0 && chunk > 0);
                r = $urandom_range(0, 99);
                if (r < lf_pct) begin
                    it.byte_in = LF_BYTE;
                end else if (r < 50) begin
                    it.byte_in = BYTE_W'($urandom_range(32, 126));
                end else if (r < 53) begin
                    it.byte_in = CR_BYTE;
                end else if (r < 57) begin
                    // keep the raw byte
                end else if (r < 92) begin
                    it.kind = KIND_READ;
                    if ($urandom_range(0, 9) != 0) begin
                        it.row = ROW_W'($urandom_range(0, NR - 1));
                        it.col = COL_W'($urandom_range(0, NC - 1));
                    end
                end else if (r < 96) begin
                    it.kind = KIND_NONE;
                end else if (r < 96 + clr_pct) begin
                    it.kind = KIND_CLEAR;
                end else begin
                    it.byte_in = LF_BYTE;
                end
                pending_items.push_back(it);
            end
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        do @(posedge aclk);
        while (pending_items.size() > 0 || s_tvalid || expected_replies.size() > 0);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (err_cnt == 0 && expected_replies.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/ttsb_pkg.sv
src/ttsb_ctrl.sv
src/ttsb_dp.sv
src/text_terminal_scroll_buffer_unit.sv
tb/sv/tb.sv
